@@ design/jsj_pkg.sv @@
// Package for the joystick servo jog controller.
// Holds the request and result payload types, the configuration and state
// records, event codes, register indexes and reset values. No dependencies.
package jsj_pkg;

  // Field widths.
  localparam int DUTY_W  = 22;
  localparam int DZ_W    = 15;
  localparam int AXIS_W  = 16;
  localparam int PART_W  = 5;
  localparam int MODE_W  = 2;
  localparam int CIDX_W  = 4;
  localparam int NUM_AXES = 5;
  localparam int AXSEL_W = 3;

  // Event kinds.
  localparam logic CMD_AXIS   = 1'b0;
  localparam logic CMD_BUTTON = 1'b1;

  // Axis and button numbers.
  localparam logic [PART_W-1:0] PART_SELECT  = 5'd0;
  localparam logic [PART_W-1:0] PART_LEFT_Y  = 5'd1;
  localparam logic [PART_W-1:0] PART_RIGHT_Y = 5'd3;
  localparam logic [PART_W-1:0] PART_GYRO_Y  = 5'd5;
  localparam logic [PART_W-1:0] PART_CIRCLE  = 5'd17;
  localparam logic [PART_W-1:0] PART_CROSS   = 5'd18;

  // Slots of the tracked axis values.
  localparam logic [AXSEL_W-1:0] AX_LY     = 3'd0;
  localparam logic [AXSEL_W-1:0] AX_RY     = 3'd1;
  localparam logic [AXSEL_W-1:0] AX_GY     = 3'd2;
  localparam logic [AXSEL_W-1:0] AX_CIRCLE = 3'd3;
  localparam logic [AXSEL_W-1:0] AX_CROSS  = 3'd4;

  // Control modes.
  localparam logic [MODE_W-1:0] MODE_STICKS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GYRO   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_STICK_DZ  = 4'd0;
  localparam logic [CIDX_W-1:0] CFG_BUTTON_DZ = 4'd1;
  localparam logic [CIDX_W-1:0] CFG_GRIP_MIN  = 4'd2;
  localparam logic [CIDX_W-1:0] CFG_GRIP_MAX  = 4'd3;
  localparam logic [CIDX_W-1:0] CFG_JA_MIN    = 4'd4;
  localparam logic [CIDX_W-1:0] CFG_JA_MAX    = 4'd5;
  localparam logic [CIDX_W-1:0] CFG_JB_MIN    = 4'd6;
  localparam logic [CIDX_W-1:0] CFG_JB_MAX    = 4'd7;

  // Configuration reset values.
  localparam logic [DZ_W-1:0]   RST_STICK_DZ  = 15'd500;
  localparam logic [DZ_W-1:0]   RST_BUTTON_DZ = 15'd350;
  localparam logic [DUTY_W-1:0] RST_GRIP_MIN  = 22'd1696325;
  localparam logic [DUTY_W-1:0] RST_GRIP_MAX  = 22'd2262995;
  localparam logic [DUTY_W-1:0] RST_JA_MIN    = 22'd700000;
  localparam logic [DUTY_W-1:0] RST_JA_MAX    = 22'd2158665;
  localparam logic [DUTY_W-1:0] RST_JB_MIN    = 22'd700000;
  localparam logic [DUTY_W-1:0] RST_JB_MAX    = 22'd1895460;

  // Setpoint reset values.
  localparam logic [DUTY_W-1:0] RST_GRIP_SP = 22'd1095460;
  localparam logic [DUTY_W-1:0] RST_JA_SP   = 22'd1458665;
  localparam logic [DUTY_W-1:0] RST_JB_SP   = 22'd1367695;

  typedef struct packed {
    logic                     cmd;
    logic [PART_W-1:0]        part_id;
    logic signed [AXIS_W-1:0] event_value;
  } jsj_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] gripper_duty;
    logic [DUTY_W-1:0] joint_a_duty;
    logic [DUTY_W-1:0] joint_b_duty;
    logic [MODE_W-1:0] control_mode;
  } jsj_out_t;

  typedef struct packed {
    logic [DZ_W-1:0]   stick_thresh;
    logic [DZ_W-1:0]   press_thresh;
    logic [DUTY_W-1:0] gripper_min;
    logic [DUTY_W-1:0] gripper_max;
    logic [DUTY_W-1:0] joint_a_min;
    logic [DUTY_W-1:0] joint_a_max;
    logic [DUTY_W-1:0] joint_b_min;
    logic [DUTY_W-1:0] joint_b_max;
  } jsj_cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0]                  gripper_sp;
    logic [DUTY_W-1:0]                  joint_a_sp;
    logic [DUTY_W-1:0]                  joint_b_sp;
    logic [MODE_W-1:0]                  mode;
    logic [NUM_AXES-1:0][AXIS_W-1:0]    last_axis;
  } jsj_state_t;

  // Select press advances the mode modulo three.
  function automatic logic [MODE_W-1:0] mode_next(input logic [MODE_W-1:0] m);
    logic [MODE_W-1:0] r;
    begin
      unique case (m)
        MODE_STICKS: r = MODE_GYRO;
        MODE_GYRO:   r = MODE_HOLD;
        MODE_HOLD:   r = MODE_STICKS;
        default:     r = MODE_GYRO;
      endcase
      return r;
    end
  endfunction

endpackage

@@ design/jsj_cfg_regs.sv @@
// Configuration register file of the joystick servo jog controller.
// Depends on jsj_pkg for the register indexes, reset values and jsj_cfg_t.
module jsj_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [jsj_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [jsj_pkg::DUTY_W-1:0]   cfg_wdata,
  output jsj_pkg::jsj_cfg_t            cfg
);
  import jsj_pkg::*;

  jsj_cfg_t cfg_r, cfg_nxt;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the register index; writes beyond the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STICK_DZ:  cfg_nxt.stick_thresh    = cfg_wdata[DZ_W-1:0];
        CFG_BUTTON_DZ: cfg_nxt.press_thresh    = cfg_wdata[DZ_W-1:0];
        CFG_GRIP_MIN:  cfg_nxt.gripper_min     = cfg_wdata;
        CFG_GRIP_MAX:  cfg_nxt.gripper_max     = cfg_wdata;
        CFG_JA_MIN:    cfg_nxt.joint_a_min     = cfg_wdata;
        CFG_JA_MAX:    cfg_nxt.joint_a_max     = cfg_wdata;
        CFG_JB_MIN:    cfg_nxt.joint_b_min     = cfg_wdata;
        CFG_JB_MAX:    cfg_nxt.joint_b_max     = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stick_thresh    <= RST_STICK_DZ;
      cfg_r.press_thresh    <= RST_BUTTON_DZ;
      cfg_r.gripper_min     <= RST_GRIP_MIN;
      cfg_r.gripper_max     <= RST_GRIP_MAX;
      cfg_r.joint_a_min     <= RST_JA_MIN;
      cfg_r.joint_a_max     <= RST_JA_MAX;
      cfg_r.joint_b_min     <= RST_JB_MIN;
      cfg_r.joint_b_max     <= RST_JB_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ design/jsj_step.sv @@
// Per-event update logic of the joystick servo jog controller.
// Computes the next setpoints, mode and tracked axis values from one event.
// Depends on jsj_pkg for the payload, state and configuration types.
module jsj_step #(
  parameter int STEP_GAIN = 5
) (
  input  jsj_pkg::jsj_in_t    item,
  input  jsj_pkg::jsj_state_t state,
  input  jsj_pkg::jsj_cfg_t   cfg,
  output jsj_pkg::jsj_state_t state_nxt
);
  import jsj_pkg::*;

  localparam int DIFF_W = AXIS_W + 1;
  localparam int GAIN_W = $clog2(STEP_GAIN + 1);
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int SUM_W  = ((DUTY_W + 1 > PROD_W) ? DUTY_W + 1 : PROD_W) + 1;
  localparam logic signed [PROD_W-1:0] GAIN_S = PROD_W'(STEP_GAIN);

  // Clamp a widened setpoint to its limits; a low hit wins over a high one.
  function automatic logic [DUTY_W-1:0] clamp_duty(
    input logic signed [SUM_W-1:0] v,
    input logic [DUTY_W-1:0]       lo,
    input logic [DUTY_W-1:0]       hi
  );
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    logic [DUTY_W-1:0]       r;
    begin
      lo_s = $signed({{(SUM_W-DUTY_W){1'b0}}, lo});
      hi_s = $signed({{(SUM_W-DUTY_W){1'b0}}, hi});
      if (v < lo_s) r = lo;
      else if (v > hi_s) r = hi;
      else r = v[DUTY_W-1:0];
      return r;
    end
  endfunction

  function automatic logic signed [SUM_W-1:0] widen_duty(input logic [DUTY_W-1:0] d);
    return $signed({{(SUM_W-DUTY_W){1'b0}}, d});
  endfunction

  logic                      is_axis;
  logic                      do_ly, do_ry, do_gy, do_circle, do_cross;
  logic                      handled;
  logic [AXSEL_W-1:0]        ax_sel;
  logic [AXIS_W-1:0]         last_val;
  logic signed [DIFF_W-1:0]  val_x, last_x, diff;
  logic signed [DIFF_W-1:0]  sdz_pos, sdz_neg, bdz_pos;
  logic                      diff_pos, diff_neg;
  logic                      stick_move, btn_move;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   prod_w, d_stick, d_btn;
  logic signed [SUM_W-1:0]   a_sum, b_sum, g_sum;

  // Decide which handler, if any, takes this event.
  always_comb begin
    is_axis   = (item.cmd == CMD_AXIS);
    do_ly     = is_axis && (state.mode == MODE_STICKS) && (item.part_id == PART_LEFT_Y);
    do_ry     = is_axis && (state.mode == MODE_STICKS) && (item.part_id == PART_RIGHT_Y);
    do_gy     = is_axis && (state.mode == MODE_GYRO) && (item.part_id == PART_GYRO_Y);
    do_circle = is_axis && (item.part_id == PART_CIRCLE);
    do_cross  = is_axis && (item.part_id == PART_CROSS);
    handled   = do_ly | do_ry | do_gy | do_circle | do_cross;
    priority if (do_ly)     ax_sel = AX_LY;
    else if (do_ry)         ax_sel = AX_RY;
    else if (do_gy)         ax_sel = AX_GY;
    else if (do_circle)     ax_sel = AX_CIRCLE;
    else                    ax_sel = AX_CROSS;
  end

  // Fetch the stored value of the selected axis.
  always_comb begin
    unique case (ax_sel)
      AX_LY:     last_val = state.last_axis[0];
      AX_RY:     last_val = state.last_axis[1];
      AX_GY:     last_val = state.last_axis[2];
      AX_CIRCLE: last_val = state.last_axis[3];
      AX_CROSS:  last_val = state.last_axis[4];
      default:   last_val = '0;
    endcase
  end

  // Change from the stored value and the dead zone tests.
  always_comb begin
    val_x    = $signed({item.event_value[AXIS_W-1], item.event_value});
    last_x   = $signed({last_val[AXIS_W-1], last_val});
    diff     = val_x - last_x;
    diff_pos = !diff[DIFF_W-1] && (|diff);
    diff_neg = diff[DIFF_W-1];
    sdz_pos  = $signed({2'b00, cfg.stick_thresh});
    sdz_neg  = -sdz_pos;
    bdz_pos  = $signed({2'b00, cfg.press_thresh});
    stick_move = ((val_x > sdz_pos) && diff_pos) || ((val_x < sdz_neg) && diff_neg);
    btn_move   = (val_x > bdz_pos) && diff_pos;
  end

  // Scale the change by the step gain.
  assign prod    = {{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff} * GAIN_S;
  assign prod_w  = {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign d_stick = stick_move ? prod_w : '0;
  assign d_btn   = btn_move ? prod_w : '0;

  // Moved setpoints before clamping.
  always_comb begin
    b_sum = widen_duty(state.joint_b_sp) - d_stick;
    a_sum = do_gy ? widen_duty(state.joint_a_sp) + d_stick
                  : widen_duty(state.joint_a_sp) - d_stick;
    g_sum = do_cross ? widen_duty(state.gripper_sp) - d_btn
                     : widen_duty(state.gripper_sp) + d_btn;
  end

  // Commit the touched setpoints, the axis value and the mode.
  always_comb begin
    state_nxt = state;
    if (do_ly || do_gy) begin
      state_nxt.joint_b_sp = clamp_duty(b_sum, cfg.joint_b_min, cfg.joint_b_max);
    end
    if (do_ry || do_gy) begin
      state_nxt.joint_a_sp = clamp_duty(a_sum, cfg.joint_a_min, cfg.joint_a_max);
    end
    if (do_circle || do_cross) begin
      state_nxt.gripper_sp = clamp_duty(g_sum, cfg.gripper_min, cfg.gripper_max);
    end
    if (handled) begin
      unique case (ax_sel)
        AX_LY:     state_nxt.last_axis[0] = item.event_value;
        AX_RY:     state_nxt.last_axis[1] = item.event_value;
        AX_GY:     state_nxt.last_axis[2] = item.event_value;
        AX_CIRCLE: state_nxt.last_axis[3] = item.event_value;
        AX_CROSS:  state_nxt.last_axis[4] = item.event_value;
        default:   state_nxt.last_axis = state.last_axis;
      endcase
    end
    if ((item.cmd == CMD_BUTTON) && (item.part_id == PART_SELECT) &&
        (item.event_value == AXIS_W'(1))) begin
      state_nxt.mode = mode_next(state.mode);
    end
  end

endmodule

@@ design/joystick_servo_jog_controller_unit.sv @@
// Top level of the joystick servo jog controller.
// Instantiates jsj_cfg_regs and jsj_step; depends on jsj_pkg.
//
// One joystick event enters per clock while the result side is not stalled,
// and each yields exactly one result: the three duty setpoints and the control
// mode after that event. An event is held in an input register; the update
// logic (jsj_step) works on it once the result register is free and writes the
// setpoint state and the result register together, so results are registered;
// throughput is one event per cycle while out_stall is low. A stalled result
// holds in the output register while one more event is taken into the input
// register; only then does in_stall rise.
// Configuration writes are taken in any cycle (cfg_ready is tied high) but
// must only be issued while no event is in flight.
module joystick_servo_jog_controller_unit #(
  parameter int STEP_GAIN = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  jsj_pkg::jsj_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output jsj_pkg::jsj_out_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [jsj_pkg::CIDX_W-1:0] cfg_index,
  input  logic [jsj_pkg::DUTY_W-1:0] cfg_wdata
);
  import jsj_pkg::*;

  jsj_cfg_t   cfg;
  jsj_in_t    in_data_r, in_data_nxt;
  logic       in_valid_r, in_valid_nxt;
  jsj_state_t state_r, state_nxt, step_state;
  jsj_out_t   out_data_r, out_data_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       advance, accept;

  jsj_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  jsj_step #(
    .STEP_GAIN (STEP_GAIN)
  ) u_step (
    .item      (in_data_r),
    .state     (state_r),
    .cfg       (cfg),
    .state_nxt (step_state)
  );

  // Pipeline control: the held request moves on when the result slot frees.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = accept || (in_valid_r && !advance);
    in_data_nxt   = accept ? in_data : in_data_r;
    out_valid_nxt = advance || (out_valid_r && out_stall);
    state_nxt     = advance ? step_state : state_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_data_nxt.gripper_duty = step_state.gripper_sp;
      out_data_nxt.joint_a_duty = step_state.joint_a_sp;
      out_data_nxt.joint_b_duty = step_state.joint_b_sp;
      out_data_nxt.control_mode = step_state.mode;
    end
  end

  // Control and setpoint state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      state_r.gripper_sp <= RST_GRIP_SP;
      state_r.joint_a_sp <= RST_JA_SP;
      state_r.joint_b_sp <= RST_JB_SP;
      state_r.mode       <= MODE_STICKS;
      state_r.last_axis  <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/jsj_checker.sv @@
// Port-level checks for the joystick servo jog controller.
// Depends on jsj_pkg; bound to joystick_servo_jog_controller_unit below.
module jsj_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input jsj_pkg::jsj_out_t out_data
);
  import jsj_pkg::*;

  // A stalled result stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // The input side only backs up when the result side is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result slot free");

  // The spare mode code is never reported.
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.control_mode != MODE_SPARE)
    else $error("unreachable control mode reported");

  // An accepted request with a free result path is followed by a valid result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |-> ##2 out_valid)
    else $error("result missing after accepted request");

endmodule

bind joystick_servo_jog_controller_unit jsj_checker u_jsj_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/tb_joystick_servo_jog_controller_unit.sv @@
// Self-checking testbench for the joystick servo jog controller.
// Predicts every setpoint and mode result in a scoreboard class, drives requests and
// register writes with plain tasks and result stalls from an always block; depends on jsj_pkg and the top level.
`timescale 1ns / 1ps

module tb_joystick_servo_jog_controller_unit;
  import jsj_pkg::*;

  localparam int GAIN             = 5;
  localparam int CYCLE_LIMIT      = 100000;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int HOLD_CYCLES      = 120;
  localparam logic [DUTY_W-1:0] DUTY_TOP = '1;

  // Predicts setpoints and mode and compares them with what the block reports.
  class servo_scoreboard;
    longint stick_dz, button_dz;
    longint grip_lo, grip_hi, ja_lo, ja_hi, jb_lo, jb_hi;
    longint grip_sp, ja_sp, jb_sp;
    logic [MODE_W-1:0] mode;
    longint last_axis[NUM_AXES];
    jsj_out_t expected_q[$];
    int mismatches;
    int accepted;
    int checked;

    function new();
      stick_dz  = RST_STICK_DZ;
      button_dz = RST_BUTTON_DZ;
      grip_lo   = RST_GRIP_MIN;
      grip_hi   = RST_GRIP_MAX;
      ja_lo     = RST_JA_MIN;
      ja_hi     = RST_JA_MAX;
      jb_lo     = RST_JB_MIN;
      jb_hi     = RST_JB_MAX;
      grip_sp   = RST_GRIP_SP;
      ja_sp     = RST_JA_SP;
      jb_sp     = RST_JB_SP;
      mode      = MODE_STICKS;
      foreach (last_axis[i]) last_axis[i] = 0;
      mismatches = 0;
      accepted   = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [DUTY_W-1:0] wdata);
      case (idx)
        CFG_STICK_DZ:  stick_dz  = wdata[DZ_W-1:0];
        CFG_BUTTON_DZ: button_dz = wdata[DZ_W-1:0];
        CFG_GRIP_MIN:  grip_lo   = wdata;
        CFG_GRIP_MAX:  grip_hi   = wdata;
        CFG_JA_MIN:    ja_lo     = wdata;
        CFG_JA_MAX:    ja_hi     = wdata;
        CFG_JB_MIN:    jb_lo     = wdata;
        CFG_JB_MAX:    jb_hi     = wdata;
        default: ;
      endcase
    endfunction

    // The lower limit wins when the limits are inverted.
    function longint limit(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // A stick moves a joint only while its deflection grows beyond the dead zone.
    function longint stick_push(longint v, longint diff);
      if (v > stick_dz) begin
        if (diff > 0) return diff * GAIN;
      end else if (v < -stick_dz) begin
        if (diff < 0) return diff * GAIN;
      end
      return 0;
    endfunction

    function void note_request(jsj_in_t r);
      longint v;
      longint push;
      jsj_out_t e;
      v = $signed(r.event_value);
      accepted++;
      if (r.cmd == CMD_AXIS) begin
        if (mode == MODE_STICKS && r.part_id == PART_LEFT_Y) begin
          jb_sp = limit(jb_sp - stick_push(v, v - last_axis[AX_LY]), jb_lo, jb_hi);
          last_axis[AX_LY] = v;
        end
        if (mode == MODE_STICKS && r.part_id == PART_RIGHT_Y) begin
          ja_sp = limit(ja_sp - stick_push(v, v - last_axis[AX_RY]), ja_lo, ja_hi);
          last_axis[AX_RY] = v;
        end
        if (mode == MODE_GYRO && r.part_id == PART_GYRO_Y) begin
          push = stick_push(v, v - last_axis[AX_GY]);
          jb_sp = limit(jb_sp - push, jb_lo, jb_hi);
          ja_sp = limit(ja_sp + push, ja_lo, ja_hi);
          last_axis[AX_GY] = v;
        end
        // Gripper pressure buttons act in every mode.
        if (r.part_id == PART_CROSS) begin
          if (v > button_dz && v - last_axis[AX_CROSS] > 0)
            grip_sp -= (v - last_axis[AX_CROSS]) * GAIN;
          grip_sp = limit(grip_sp, grip_lo, grip_hi);
          last_axis[AX_CROSS] = v;
        end
        if (r.part_id == PART_CIRCLE) begin
          if (v > button_dz && v - last_axis[AX_CIRCLE] > 0)
            grip_sp += (v - last_axis[AX_CIRCLE]) * GAIN;
          grip_sp = limit(grip_sp, grip_lo, grip_hi);
          last_axis[AX_CIRCLE] = v;
        end
      end else if (r.part_id == PART_SELECT && v == 1) begin
        case (mode)
          MODE_STICKS: mode = MODE_GYRO;
          MODE_GYRO:   mode = MODE_HOLD;
          MODE_HOLD:   mode = MODE_STICKS;
          default:     mode = MODE_GYRO;
        endcase
      end
      e.gripper_duty = grip_sp[DUTY_W-1:0];
      e.joint_a_duty = ja_sp[DUTY_W-1:0];
      e.joint_b_duty = jb_sp[DUTY_W-1:0];
      e.control_mode = mode;
      expected_q.push_back(e);
    endfunction

    function void check_result(jsj_out_t got);
      jsj_out_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: %h", got);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.gripper_duty !== e.gripper_duty) begin
        $error("gripper_duty: expected %0d, got %0d", e.gripper_duty, got.gripper_duty);
        mismatches++;
      end
      if (got.joint_a_duty !== e.joint_a_duty) begin
        $error("joint_a_duty: expected %0d, got %0d", e.joint_a_duty, got.joint_a_duty);
        mismatches++;
      end
      if (got.joint_b_duty !== e.joint_b_duty) begin
        $error("joint_b_duty: expected %0d, got %0d", e.joint_b_duty, got.joint_b_duty);
        mismatches++;
      end
      if (got.control_mode !== e.control_mode) begin
        $error("control_mode: expected %0d, got %0d", e.control_mode, got.control_mode);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  jsj_in_t            in_data;
  logic               out_valid;
  logic               out_stall = 1'b0;
  jsj_out_t           out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index;
  logic [DUTY_W-1:0]  cfg_wdata;

  servo_scoreboard sb = new();
  bit     tx_quiet = 1'b0;
  bit     rx_quiet = 1'b0;
  int     hold_requests = 0;
  int     hold_served = 0;
  int     hold_left = 0;
  int     cycles = 0;
  int     settings_used = 0;
  longint sent_axis[32];

  joystick_servo_jog_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_joystick_servo_jog_controller_unit NOT OK");
      $finish;
    end
  end

  // Sample every handshake at the rising edge, results before new requests.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 15);
    end
  end

  task automatic send_request(jsj_in_t r);
    @(negedge clk);
    while (!tx_quiet && $urandom_range(0, 99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic poke(logic cmd, logic [PART_W-1:0] part, int value);
    jsj_in_t r;
    r.cmd = cmd;
    r.part_id = part;
    r.event_value = 16'(value);
    send_request(r);
  endtask

  // Wait until every request has produced its result and the pipeline is empty.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [DUTY_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(logic [DUTY_W-1:0] sdz, logic [DUTY_W-1:0] bdz,
                               logic [DUTY_W-1:0] g_lo, logic [DUTY_W-1:0] g_hi,
                               logic [DUTY_W-1:0] a_lo, logic [DUTY_W-1:0] a_hi,
                               logic [DUTY_W-1:0] b_lo, logic [DUTY_W-1:0] b_hi);
    cfg_write(CFG_STICK_DZ, sdz);
    cfg_write(CFG_BUTTON_DZ, bdz);
    cfg_write(CFG_GRIP_MIN, g_lo);
    cfg_write(CFG_GRIP_MAX, g_hi);
    cfg_write(CFG_JA_MIN, a_lo);
    cfg_write(CFG_JA_MAX, a_hi);
    cfg_write(CFG_JB_MIN, b_lo);
    cfg_write(CFG_JB_MAX, b_hi);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // Mostly growing deflections on the tracked axes, plus mode changes and noise.
  function automatic jsj_in_t random_request();
    jsj_in_t r;
    int pick;
    int step;
    logic [PART_W-1:0] p;
    longint prev;
    longint nv;
    longint dz;
    pick = $urandom_range(0, 99);
    r.cmd = CMD_AXIS;
    if (pick < 8) begin
      r.cmd = CMD_BUTTON;
      r.part_id = PART_SELECT;
      r.event_value = 16'sd1;
    end else if (pick < 14) begin
      r.cmd = CMD_BUTTON;
      r.part_id = PART_W'($urandom_range(0, 31));
      r.event_value = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
    end else if (pick < 20) begin
      r.part_id = PART_W'($urandom_range(0, 31));
      r.event_value = 16'($urandom);
    end else begin
      case ($urandom_range(0, 4))
        0:       p = PART_LEFT_Y;
        1:       p = PART_RIGHT_Y;
        2:       p = PART_GYRO_Y;
        3:       p = PART_CIRCLE;
        default: p = PART_CROSS;
      endcase
      prev = sent_axis[p];
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        nv = $signed(16'($urandom));
      end else if (pick < 22) begin
        // Land right at the edge of the dead zone.
        dz = (p == PART_CIRCLE || p == PART_CROSS) ? sb.button_dz : sb.stick_dz;
        step = $urandom_range(0, 4);
        nv = dz + step - 2;
        if ($urandom_range(0, 1) == 0) nv = -nv;
      end else begin
        step = $urandom_range(0, 4000);
        if ((prev < 0) ^ ($urandom_range(0, 3) == 0)) nv = prev - step;
        else nv = prev + step;
      end
      if (nv > 32767) nv = 32767;
      if (nv < -32768) nv = -32768;
      sent_axis[p] = nv;
      r.part_id = p;
      r.event_value = nv[AXIS_W-1:0];
    end
    return r;
  endfunction

  task automatic random_phase();
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_request(random_request());
    drain();
  endtask

  initial begin
    foreach (sent_axis[i]) sent_axis[i] = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_STICK_DZ;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests at the reset settings.
    poke(CMD_BUTTON, 5'd5, 1);
    poke(CMD_AXIS, PART_LEFT_Y, 32767);
    poke(CMD_AXIS, PART_LEFT_Y, -32768);
    poke(CMD_AXIS, PART_RIGHT_Y, 600);
    poke(CMD_AXIS, PART_RIGHT_Y, 400);
    poke(CMD_AXIS, PART_RIGHT_Y, -32768);
    poke(CMD_AXIS, PART_GYRO_Y, 20000);
    poke(CMD_AXIS, PART_CROSS, 1000);
    poke(CMD_AXIS, PART_CIRCLE, 32767);
    poke(CMD_BUTTON, PART_SELECT, 0);
    poke(CMD_BUTTON, PART_SELECT, 1);
    poke(CMD_AXIS, PART_GYRO_Y, 20000);
    poke(CMD_AXIS, PART_GYRO_Y, 10000);
    poke(CMD_AXIS, PART_GYRO_Y, -32768);
    poke(CMD_AXIS, PART_LEFT_Y, 0);
    poke(CMD_BUTTON, PART_SELECT, -1);
    poke(CMD_BUTTON, PART_SELECT, 1);
    poke(CMD_AXIS, PART_RIGHT_Y, 32767);
    poke(CMD_AXIS, PART_CROSS, 32767);
    poke(CMD_AXIS, 5'd19, -32768);
    poke(CMD_AXIS, 5'd31, 32767);
    poke(CMD_BUTTON, 5'd31, 1);
    poke(CMD_BUTTON, PART_CROSS, 1);
    poke(CMD_BUTTON, PART_SELECT, 1);
    poke(CMD_AXIS, PART_CROSS, -32768);
    drain();

    // Typical settings; the receiver holds off at the start so the block backs up.
    load_settings(DUTY_W'($urandom_range(100, 3000)), DUTY_W'($urandom_range(100, 3000)),
                  22'd1500000, 22'd2500000, 22'd600000, 22'd2200000,
                  22'd650000, 22'd2000000);
    hold_requests++;
    random_phase();

    // Zero dead zones and the widest limits, with no idling on either side.
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    load_settings('0, '0, '0, DUTY_TOP, '0, DUTY_TOP, '0, DUTY_TOP);
    random_phase();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Dead zones at their top with the upper write bits set, and inverted limits.
    load_settings(DUTY_TOP, DUTY_TOP, 22'd3000000, 22'd1000000,
                  22'd2500000, 22'd500000, DUTY_TOP, '0);
    random_phase();

    // Fully random register values.
    load_settings(DUTY_W'($urandom), DUTY_W'($urandom), DUTY_W'($urandom), DUTY_W'($urandom),
                  DUTY_W'($urandom), DUTY_W'($urandom), DUTY_W'($urandom), DUTY_W'($urandom));
    random_phase();

    // Narrow windows, gripper pinned to a single value.
    load_settings(22'd500, '0, 22'd2000000, 22'd2000000,
                  22'd1400000, 22'd1500000, 22'd1300000, 22'd1400000);
    random_phase();

    $display("Run covered %0d requests and %0d checked results over %0d register settings.",
             sb.accepted, sb.checked, settings_used + 1);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_joystick_servo_jog_controller_unit OK");
    end else begin
      $display("tb_joystick_servo_jog_controller_unit NOT OK");
    end
    $finish;
  end

endmodule
